>>> rtl/s2d_pkg.sv
// Shared types and constants for the signed integer to decimal ASCII converter.
`timescale 1ns / 1ps

package s2d_pkg;

  localparam int BIN_W      = 32;
  localparam int DIGIT_W    = 4;
  localparam int NUM_DIGITS = 10;
  localparam int BCD_W      = DIGIT_W * NUM_DIGITS;
  localparam int CHAR_W     = 6;
  localparam int CNT_W      = $clog2(BIN_W);
  localparam int LEFT_W     = $clog2(NUM_DIGITS + 1);

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

  typedef struct packed {
    logic             neg;
    logic [BCD_W-1:0] digits;
  } bcd_item_t;

endpackage

>>> rtl/signed_int_to_decimal_ascii.sv
// Top level: signed 32-bit integer to decimal ASCII characters, one per result item.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall  in_value (32-bit signed)
//   out_     output     out_valid/out_stall out_char_code (6), out_last_char (1)
//
// Conversion runs bit-serially in the shift-add-3 unit, which then hands the digits to
// the emitter; the next item converts while the previous one is emitted, so a new item
// can be accepted before the previous one has left the output.
// Emission: leading-zero strip, then one character per cycle when out_ is not stalled.
// Reset is synchronous, active low, and clears all handshake state.
// A stall on out_ holds the current character; in_stall rises while a conversion runs.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [s2d_pkg::BIN_W-1:0] in_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [s2d_pkg::CHAR_W-1:0]       out_char_code,
  output logic                             out_last_char
);

  logic                item_valid;
  logic                item_take;
  s2d_pkg::bcd_item_t  item;

  s2d_dabble u_dabble (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_value   (in_value),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  s2d_emit u_emit (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_valid    (item_valid),
    .item          (item),
    .item_take     (item_take),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_char_code (out_char_code),
    .out_last_char (out_last_char)
  );

endmodule

>>> rtl/s2d_dabble.sv
// Bit-serial binary to BCD conversion of the magnitude, one shift-add-3 step per cycle.
`timescale 1ns / 1ps

module s2d_dabble (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [s2d_pkg::BIN_W-1:0] in_value,
  output logic                         item_valid,
  output s2d_pkg::bcd_item_t           item,
  input  logic                         item_take
);

  logic                          busy_r, busy_nxt;
  logic                          full_r, full_nxt;
  logic [s2d_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [s2d_pkg::BIN_W-1:0]     bin_r, bin_nxt;
  logic [s2d_pkg::BCD_W-1:0]     bcd_r, bcd_nxt;
  logic                          neg_r, neg_nxt;
  logic [s2d_pkg::BCD_W-1:0]     adj;
  logic [s2d_pkg::BIN_W-1:0]     raw;
  logic [s2d_pkg::BIN_W-1:0]     mag;
  logic                          start;

  assign raw      = in_value;
  assign mag      = raw[s2d_pkg::BIN_W-1] ? (~raw + 32'd1) : raw;
  assign in_stall = busy_r | (full_r & ~item_take);
  assign start    = in_valid & ~in_stall;

  assign item_valid  = full_r;
  assign item.neg    = neg_r;
  assign item.digits = bcd_r;

  always_comb begin
    for (int i = 0; i < s2d_pkg::NUM_DIGITS; i++) begin
      if (bcd_r[i*s2d_pkg::DIGIT_W +: s2d_pkg::DIGIT_W] >= 4'd5) begin
        adj[i*s2d_pkg::DIGIT_W +: s2d_pkg::DIGIT_W] =
          bcd_r[i*s2d_pkg::DIGIT_W +: s2d_pkg::DIGIT_W] + 4'd3;
      end else begin
        adj[i*s2d_pkg::DIGIT_W +: s2d_pkg::DIGIT_W] =
          bcd_r[i*s2d_pkg::DIGIT_W +: s2d_pkg::DIGIT_W];
      end
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    full_nxt = full_r;
    cnt_nxt  = cnt_r;
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    neg_nxt  = neg_r;
    if (item_take) begin
      full_nxt = 1'b0;
    end
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = s2d_pkg::CNT_W'(s2d_pkg::BIN_W - 1);
      bin_nxt  = mag;
      bcd_nxt  = '0;
      neg_nxt  = raw[s2d_pkg::BIN_W-1];
    end else if (busy_r) begin
      bcd_nxt = {adj[s2d_pkg::BCD_W-2:0], bin_r[s2d_pkg::BIN_W-1]};
      bin_nxt = {bin_r[s2d_pkg::BIN_W-2:0], 1'b0};
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        full_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      full_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      full_r <= full_nxt;
      cnt_r  <= cnt_nxt;
    end
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
    neg_r <= neg_nxt;
  end

`ifndef ASSERT_OFF
  a_busy_full_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(busy_r && full_r))
    else $error("converter busy while holding a finished item");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r && !full_r)
    else $error("accepted item did not start conversion");

  a_done_full: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && cnt_r == '0) |=> full_r)
    else $error("conversion end did not post the item");
`endif

endmodule

>>> rtl/s2d_emit.sv
// Leading-zero strip and character emission, one digit per cycle while the output is not stalled, with output register.
`timescale 1ns / 1ps

module s2d_emit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          item_valid,
  input  s2d_pkg::bcd_item_t            item,
  output logic                          item_take,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [s2d_pkg::CHAR_W-1:0]    out_char_code,
  output logic                          out_last_char
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_STRIP  = 2'd1;
  localparam logic [1:0] ST_SIGN   = 2'd2;
  localparam logic [1:0] ST_DIGITS = 2'd3;

  logic [1:0]                     st_r, st_nxt;
  logic [s2d_pkg::BCD_W-1:0]      dig_r, dig_nxt;
  logic [s2d_pkg::LEFT_W-1:0]     left_r, left_nxt;
  logic                           neg_r, neg_nxt;
  logic                           ov_r, ov_nxt;
  logic [s2d_pkg::CHAR_W-1:0]     char_r, char_nxt;
  logic                           last_r, last_nxt;
  logic [s2d_pkg::DIGIT_W-1:0]    top;
  logic                           can_load;

  assign top       = dig_r[s2d_pkg::BCD_W-1 -: s2d_pkg::DIGIT_W];
  assign can_load  = ~ov_r | ~out_stall;
  assign item_take = item_valid & (st_r == ST_IDLE);

  assign out_valid     = ov_r;
  assign out_char_code = char_r;
  assign out_last_char = last_r;

  always_comb begin
    st_nxt   = st_r;
    dig_nxt  = dig_r;
    left_nxt = left_r;
    neg_nxt  = neg_r;
    ov_nxt   = ov_r & out_stall;
    char_nxt = char_r;
    last_nxt = last_r;
    unique case (st_r)
      ST_IDLE: begin
        if (item_take) begin
          dig_nxt  = item.digits;
          left_nxt = s2d_pkg::LEFT_W'(s2d_pkg::NUM_DIGITS);
          neg_nxt  = item.neg;
          st_nxt   = ST_STRIP;
        end
      end
      ST_STRIP: begin
        if (top == '0 && left_r > s2d_pkg::LEFT_W'(1)) begin
          dig_nxt  = dig_r << s2d_pkg::DIGIT_W;
          left_nxt = left_r - 1'b1;
        end else begin
          st_nxt = neg_r ? ST_SIGN : ST_DIGITS;
        end
      end
      ST_SIGN: begin
        if (can_load) begin
          ov_nxt   = 1'b1;
          char_nxt = s2d_pkg::CHAR_MINUS;
          last_nxt = 1'b0;
          st_nxt   = ST_DIGITS;
        end
      end
      ST_DIGITS: begin
        if (can_load) begin
          ov_nxt   = 1'b1;
          char_nxt = s2d_pkg::CHAR_ZERO + {2'b00, top};
          last_nxt = (left_r == s2d_pkg::LEFT_W'(1));
          dig_nxt  = dig_r << s2d_pkg::DIGIT_W;
          left_nxt = left_r - 1'b1;
          if (left_r == s2d_pkg::LEFT_W'(1)) begin
            st_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
    dig_r  <= dig_nxt;
    left_r <= left_nxt;
    neg_r  <= neg_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

`ifndef ASSERT_OFF
  a_sign_neg: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_SIGN) |-> neg_r)
    else $error("minus sign pending for a non-negative item");

  a_left_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != ST_IDLE) |-> (left_r != '0 &&
                           left_r <= s2d_pkg::LEFT_W'(s2d_pkg::NUM_DIGITS)))
    else $error("digit count out of range");

  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> (char_r == s2d_pkg::CHAR_MINUS ||
              (char_r >= s2d_pkg::CHAR_ZERO && char_r <= 6'd57)))
    else $error("emitted code is not a digit or minus");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_nxt && !(ov_r && out_stall) && last_nxt) |=> (st_r == ST_IDLE))
    else $error("final character emitted without ending the item");
`endif

endmodule

>>> test/signed_int_to_decimal_ascii_tb.sv
// Testbench for the signed 32-bit integer to decimal ASCII converter.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_tb;

  typedef struct packed {
    logic [s2d_pkg::CHAR_W-1:0] code;
    logic                       last;
  } text_char_t;

  logic                             clk;
  logic                             rst_n;
  logic                             in_valid;
  logic                             in_stall;
  logic signed [s2d_pkg::BIN_W-1:0] in_value;
  logic                             out_valid;
  logic                             out_stall;
  logic [s2d_pkg::CHAR_W-1:0]       out_char_code;
  logic                             out_last_char;

  text_char_t expected_text[$];
  text_char_t want;
  int         errors;
  bit         send_idle_en;
  bit         recv_idle_en;
  int         stall_left;
  int         holdoff_left;
  bit         holdoff_req;

  signed_int_to_decimal_ascii uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_char_code(out_char_code),
    .out_last_char(out_last_char)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic void predict_text(logic signed [s2d_pkg::BIN_W-1:0] value);
    logic [s2d_pkg::BIN_W-1:0] mag;
    logic [3:0]                digs[s2d_pkg::NUM_DIGITS];
    int                        n;
    mag = value[s2d_pkg::BIN_W-1] ? (~value + 32'd1) : value;
    n = 0;
    do begin
      digs[n] = 4'(mag % 10);
      mag = mag / 10;
      n++;
    end while (mag != 0 && n < s2d_pkg::NUM_DIGITS);
    if (value[s2d_pkg::BIN_W-1]) begin
      expected_text.push_back('{code: s2d_pkg::CHAR_MINUS, last: 1'b0});
    end
    for (int d = n - 1; d >= 0; d--) begin
      expected_text.push_back('{code: s2d_pkg::CHAR_ZERO + s2d_pkg::CHAR_W'(digs[d]),
                                last: (d == 0)});
    end
  endfunction

  function automatic logic signed [s2d_pkg::BIN_W-1:0] random_value();
    int unsigned               ndig;
    longint unsigned           span;
    logic [s2d_pkg::BIN_W-1:0] mag;
    ndig = $urandom_range(1, 10);
    if (ndig == 10) return $urandom;
    span = 1;
    repeat (ndig) span = span * 10;
    mag = s2d_pkg::BIN_W'($urandom % span);
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  // Enter at a falling edge; return at a falling edge with in_valid still high.
  task automatic send_value(logic signed [s2d_pkg::BIN_W-1:0] value);
    int gap;
    gap = send_idle_en ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_value = value;
    do @(posedge clk); while (in_stall);
    predict_text(value);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (expected_text.size() != 0) @(negedge clk);
  endtask

  task automatic test_directed();
    logic signed [s2d_pkg::BIN_W-1:0] vals[$];
    vals = '{0, 1, -1, 7, -7, 9, 10, -10, 99, 100, -100, 32'sd2147483647,
             32'h8000_0000, 32'h8000_0001, 1000000000, 999999999, -999999999,
             1234567890, -1234567890, 32'h5555_5555, 32'hAAAA_AAAA, 1000000001};
    send_idle_en = 1'b0;
    recv_idle_en = 1'b0;
    foreach (vals[i]) send_value(vals[i]);
  endtask

  task automatic test_backpressure();
    send_idle_en = 1'b0;
    recv_idle_en = 1'b1;
    @(posedge clk);
    holdoff_req = 1'b1;
    @(negedge clk);
    repeat (20) send_value(random_value());
  endtask

  task automatic test_random();
    for (int i = 0; i < 200; i++) begin
      if (i % 25 == 0) begin
        send_idle_en = ($urandom_range(0, 3) != 0);
        recv_idle_en = ($urandom_range(0, 3) != 0);
      end
      send_value(random_value());
    end
  endtask

  always @(negedge clk) begin
    if (holdoff_req) begin
      holdoff_left = 400;
      holdoff_req  = 1'b0;
    end
    if (holdoff_left > 0) begin
      out_stall <= 1'b1;
      holdoff_left = holdoff_left - 1;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_text.size() == 0) begin
        $error("unexpected item: char_code %0d last_char %0b", out_char_code, out_last_char);
        errors++;
      end else begin
        want = expected_text.pop_front();
        if (out_char_code !== want.code) begin
          $error("char_code: expected %0d, actual %0d", want.code, out_char_code);
          errors++;
        end
        if (out_last_char !== want.last) begin
          $error("last_char: expected %0b, actual %0b", want.last, out_last_char);
          errors++;
        end
      end
      stall_left = recv_idle_en ? $urandom_range(0, 3) : 0;
    end
  end

  initial begin
    errors       = 0;
    stall_left   = 0;
    holdoff_left = 0;
    holdoff_req  = 1'b0;
    send_idle_en = 1'b0;
    recv_idle_en = 1'b0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_value     = '0;
    out_stall    = 1'b0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    wait_drained();
    test_backpressure();
    wait_drained();
    test_random();
    wait_drained();

    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/s2d_pkg.sv
rtl/s2d_dabble.sv
rtl/s2d_emit.sv
rtl/signed_int_to_decimal_ascii.sv
test/signed_int_to_decimal_ascii_tb.sv
